// ===== src/mdds_pkg.sv =====
// Shared types and constants for the maximum dot-product direction search block.
package mdds_pkg;

    // Fixed field widths of the item and result channels.
    localparam int COMPONENT_BITS = 16;
    localparam int INDEX_W        = 12;
    localparam int COUNT_W        = 13;
    localparam int PROD_W         = 2 * COMPONENT_BITS;
    localparam int SCORE_W        = PROD_W + 2;
    localparam int OUT_SCORE_W    = PROD_W + 1;
    localparam int VEC_W          = 3 * COMPONENT_BITS;

    // Default table depth.
    localparam int DEF_MAX_ENTRIES = 4096;

    // Starting score of a scan: -2.0 in Q4.30.
    localparam logic signed [SCORE_W-1:0] MINUS_TWO =
        {{(SCORE_W - PROD_W + 1){1'b1}}, {(PROD_W - 1){1'b0}}};

    // Command codes of an input item.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_POST
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic load_wr;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_full;
    } t_dp_status;

endpackage

// ===== src/mdds_ctrl.sv =====
// Controller state machine that sequences loads, table scans and result hand-off.
module mdds_ctrl
    import mdds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_command,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_command == CMD_QUERY) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!i_status.out_full || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands and the input stall.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.start   = i_in_valid && i_command == CMD_QUERY;
                o_cmd.load_wr = i_in_valid && i_command == CMD_LOAD;
            end
            S_SCAN: begin
                o_cmd.rd_en = !i_status.scan_done;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_POST: begin
                o_cmd.out_load = !i_status.out_full || !i_out_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/mdds_datapath.sv =====
// Datapath: direction table memory, dot-product pipeline, running best and result register.
module mdds_datapath
    import mdds_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    output t_dp_status                      o_status,
    input  logic                            i_cfg_wr_en,
    input  logic [COUNT_W-1:0]              i_cfg_wr_data,
    input  logic [INDEX_W-1:0]              i_entry_index,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_x,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_y,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_z,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [INDEX_W-1:0]              o_best_index,
    output logic signed [OUT_SCORE_W-1:0]   o_best_score
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);

    // Configuration and query state.
    logic [COUNT_W-1:0]               r_cell_count;
    logic [CNTW-1:0]                  r_limit;
    logic [CNTW-1:0]                  r_scan_pos;
    logic signed [COMPONENT_BITS-1:0] r_qx;
    logic signed [COMPONENT_BITS-1:0] r_qy;
    logic signed [COMPONENT_BITS-1:0] r_qz;

    // Table memory and pipeline stages.
    logic [VEC_W-1:0]                 r_mem [MAX_ENTRIES];
    logic [VEC_W-1:0]                 r_rd_data;
    logic                             r_v1;
    logic                             r_v2;
    logic [AW-1:0]                    r_idx1;
    logic [AW-1:0]                    r_idx2;
    logic signed [PROD_W-1:0]         r_px;
    logic signed [PROD_W-1:0]         r_py;
    logic signed [PROD_W-1:0]         r_pz;

    // Running best and result register.
    logic signed [SCORE_W-1:0]        r_best_score;
    logic [AW-1:0]                    r_best_idx;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [INDEX_W-1:0]               r_out_index;
    logic signed [OUT_SCORE_W-1:0]    r_out_score;

    logic                             w_idx_ok;
    logic [AW-1:0]                    w_wr_addr;
    logic [CNTW-1:0]                  w_limit;
    logic signed [COMPONENT_BITS-1:0] w_ex;
    logic signed [COMPONENT_BITS-1:0] w_ey;
    logic signed [COMPONENT_BITS-1:0] w_ez;
    logic signed [SCORE_W-1:0]        w_sum;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_cell_count <= i_cfg_wr_data;
        end
    end

    // Scan limit saturates at the table depth.
    always_comb begin
        if (32'(r_cell_count) > 32'(MAX_ENTRIES)) begin
            w_limit = CNTW'(MAX_ENTRIES);
        end else begin
            w_limit = CNTW'(r_cell_count);
        end
    end

    // Query setup and scan address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
        end else if (i_cmd.start) begin
            r_scan_pos <= '0;
        end else if (i_cmd.rd_en) begin
            r_scan_pos <= r_scan_pos + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_limit <= w_limit;
            r_qx    <= i_vec_x;
            r_qy    <= i_vec_y;
            r_qz    <= i_vec_z;
        end
    end

    // Table write for loads; indexes beyond the table are dropped.
    assign w_idx_ok  = 32'(i_entry_index) < 32'(MAX_ENTRIES);
    assign w_wr_addr = AW'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && w_idx_ok) begin
            r_mem[w_wr_addr] <= {i_vec_x, i_vec_y, i_vec_z};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_scan_pos[AW-1:0]];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    // Component products of the entry read last cycle.
    assign w_ex = r_rd_data[3*COMPONENT_BITS-1:2*COMPONENT_BITS];
    assign w_ey = r_rd_data[2*COMPONENT_BITS-1:COMPONENT_BITS];
    assign w_ez = r_rd_data[COMPONENT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_scan_pos[AW-1:0];
        r_idx2 <= r_idx1;
        r_px   <= w_ex * r_qx;
        r_py   <= w_ey * r_qy;
        r_pz   <= w_ez * r_qz;
    end

    // Sum of products and strict compare against the running best.
    assign w_sum = SCORE_W'(r_px) + SCORE_W'(r_py) + SCORE_W'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best_score <= MINUS_TWO;
            r_best_idx   <= '0;
        end else if (r_v2 && w_sum > r_best_score) begin
            r_best_score <= w_sum;
            r_best_idx   <= r_idx2;
        end
    end

    // Result register: filled on command, emptied by an output transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= INDEX_W'(r_best_idx);
            r_out_score <= r_best_score[OUT_SCORE_W-1:0];
        end
    end

    // Status back to the controller.
    assign o_status.scan_done = (r_scan_pos == r_limit);
    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_full  = r_out_valid;

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_index;
    assign o_best_score = r_out_score;

endmodule

// ===== src/max_dot_direction_search_core.sv =====
// Top level of the maximum dot-product direction search block.
//
// A load item writes one Q1.15 direction vector into the table; a load with an index at
// or beyond the table depth is dropped. A query reads the table one entry at a time,
// sees the end of the scan, lets the product and compare stages drain, and then places
// the result in the output register. cell_count above the table depth scans the whole
// table; cell_count of zero returns index 0 and score -2.0. Input stays stalled for the
// whole query, so the next item can be transferred only once the result has been placed
// in the output register, and a result waiting in the output register holds the next
// query at its end until the result has been transferred. The table has no reset, so
// only entries loaded since reset should be scanned.
module max_dot_direction_search_core
    import mdds_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [COUNT_W-1:0]               i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [INDEX_W-1:0]               i_entry_index,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_x,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_y,
    input  logic signed [COMPONENT_BITS-1:0] i_vec_z,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [INDEX_W-1:0]               o_best_index,
    output logic signed [OUT_SCORE_W-1:0]    o_best_score
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    mdds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall)
    );

    // Table, arithmetic and result register.
    mdds_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_entry_index (i_entry_index),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_best_index  (o_best_index),
        .o_best_score  (o_best_score)
    );

`ifndef SYNTH
    // No input transfer while entries are still in flight in the pipeline.
    a_stall_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.pipe_busy |-> o_in_stall)
        else $error("input not stalled while the scan pipeline is busy");

    // A result is captured only after the last entry has been compared.
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_status.pipe_busy)
        else $error("result captured while the scan pipeline is busy");

    // A table write never overlaps a scan.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_wr |-> !w_status.pipe_busy && !w_cmd.rd_en)
        else $error("table write during a scan");

    // A query starts with an empty pipeline.
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> !w_status.pipe_busy)
        else $error("pipeline not empty after query start");
`endif

endmodule

// ===== tb/tb_max_dot_direction_search_core.sv =====
// Self-checking testbench for the maximum dot-product direction search core.
`timescale 1ns / 100ps

module tb_max_dot_direction_search_core;
    import mdds_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int QUIET_CYCLES = 16;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_LIMIT = 10;
    localparam int FILL_ENTRIES = 64;

    localparam logic signed [COMPONENT_BITS-1:0] COMP_MIN = 16'sh8000;
    localparam logic signed [COMPONENT_BITS-1:0] COMP_MAX = 16'sh7fff;

    // One direction vector as stored in the table.
    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] x;
        logic signed [COMPONENT_BITS-1:0] y;
        logic signed [COMPONENT_BITS-1:0] z;
    } t_dir_vec;

    // Winning entry of one query.
    typedef struct {
        logic [INDEX_W-1:0]             entry;
        logic signed [OUT_SCORE_W-1:0]  score;
    } t_best_match;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]               i_cfg_wr_data = '0;
    logic                             i_in_valid    = 1'b0;
    logic                             o_in_stall;
    logic                             i_command     = CMD_LOAD;
    logic [INDEX_W-1:0]               i_entry_index = '0;
    logic signed [COMPONENT_BITS-1:0] i_vec_x       = '0;
    logic signed [COMPONENT_BITS-1:0] i_vec_y       = '0;
    logic signed [COMPONENT_BITS-1:0] i_vec_z       = '0;
    logic                             o_out_valid;
    logic                             i_out_stall   = 1'b0;
    logic [INDEX_W-1:0]               o_best_index;
    logic signed [OUT_SCORE_W-1:0]    o_best_score;

    // Predictor state: the table contents and the scan length register.
    t_dir_vec           dir_table [DEF_MAX_ENTRIES];
    logic [COUNT_W-1:0] cell_count_cfg = '0;
    t_best_match        pending_matches [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int loads_sent      = 0;
    int queries_sent    = 0;
    int matches_checked = 0;
    int count_writes    = 0;

    max_dot_direction_search_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_best_index  (o_best_index),
        .o_best_score  (o_best_score)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Scan the first cell_count entries and keep the first strictly greater dot product.
    function automatic t_best_match search_best(input t_dir_vec q);
        t_best_match              best;
        logic signed [SCORE_W-1:0] best_score;
        logic signed [SCORE_W-1:0] dot;
        int                       limit;
        int                       n;
        limit = (cell_count_cfg > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(cell_count_cfg);
        best_score = MINUS_TWO;
        best.entry = '0;
        for (n = 0; n < limit; n++) begin
            dot = $signed(dir_table[n].x) * $signed(q.x)
                + $signed(dir_table[n].y) * $signed(q.y)
                + $signed(dir_table[n].z) * $signed(q.z);
            if (dot > best_score) begin
                best_score = dot;
                best.entry = INDEX_W'(n);
            end
        end
        best.score = best_score[OUT_SCORE_W-1:0];
        return best;
    endfunction

    // Component values lean toward the extremes and the values around zero.
    function automatic logic signed [COMPONENT_BITS-1:0] random_component();
        case ($urandom_range(7))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return '0;
            3: return -16'sd1;
            default: return COMPONENT_BITS'($urandom);
        endcase
    endfunction

    function automatic t_dir_vec random_vec();
        t_dir_vec v;
        v.x = random_component();
        v.y = random_component();
        v.z = random_component();
        return v;
    endfunction

    function automatic t_dir_vec make_vec(input int x, input int y, input int z);
        t_dir_vec v;
        v.x = COMPONENT_BITS'(x);
        v.y = COMPONENT_BITS'(y);
        v.z = COMPONENT_BITS'(z);
        return v;
    endfunction

    task automatic flag_error(input string msg);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Offer one item, wait for its transfer, update the predictor, then maybe leave a gap.
    // The stall is sampled between edges so that it is the value seen by the accepting edge.
    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input t_dir_vec v);
        logic stalled;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_vec_x       <= v.x;
        i_vec_y       <= v.y;
        i_vec_z       <= v.z;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (cmd == CMD_LOAD) begin
            if (idx < DEF_MAX_ENTRIES) begin
                dir_table[idx] = v;
            end
            loads_sent++;
        end else begin
            pending_matches.insert(pending_matches.size(), search_best(v));
            queries_sent++;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stop offering items and let every outstanding result and load finish.
    task automatic wait_until_quiet();
        i_in_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cell_count(input logic [COUNT_W-1:0] count);
        wait_until_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        cell_count_cfg  = count;
        count_writes++;
    endtask

    // Queries against the reset scan length of zero.
    task automatic test_empty_scan();
        send_item(CMD_QUERY, '0, make_vec(32767, 32767, 32767));
        send_item(CMD_QUERY, '1, make_vec(-32768, -32768, -32768));
        send_item(CMD_QUERY, 12'h5a5, make_vec(0, 0, 0));
    endtask

    // Hand-built table: extreme components, ties, scores below and exactly at -2.0.
    task automatic test_directed_table();
        send_item(CMD_LOAD, 12'd0, make_vec(-32768, -32768, -32768));
        send_item(CMD_LOAD, 12'd1, make_vec(32767, 32767, 32767));
        send_item(CMD_LOAD, 12'd2, make_vec(0, 0, 0));
        send_item(CMD_LOAD, 12'd3, make_vec(32767, 0, 0));
        send_item(CMD_LOAD, 12'd4, make_vec(0, -32768, 0));
        send_item(CMD_LOAD, 12'd5, make_vec(32767, 0, 0));
        send_item(CMD_LOAD, 12'd6, make_vec(-1, -1, -1));
        send_item(CMD_LOAD, 12'd7, make_vec(0, 0, 32767));
        // A single entry that scores below -2.0, then one that scores exactly -2.0.
        set_cell_count(13'd1);
        send_item(CMD_QUERY, '0, make_vec(32767, 32767, 32767));
        send_item(CMD_QUERY, '0, make_vec(32767, 32767, 2));
        // Largest possible score, a tie between two entries, and an all-zero query.
        set_cell_count(13'd8);
        send_item(CMD_QUERY, '0, make_vec(-32768, -32768, -32768));
        send_item(CMD_QUERY, '0, make_vec(32767, 0, -32768));
        send_item(CMD_QUERY, '0, make_vec(0, 0, 0));
        send_item(CMD_QUERY, '0, make_vec(-1, 1, -32768));
        set_cell_count(13'd3);
        send_item(CMD_QUERY, '0, make_vec(-32768, 32767, 0));
        set_cell_count(13'd0);
        send_item(CMD_QUERY, '0, make_vec(32767, 32767, 32767));
    endtask

    // Fill the rest of the scanned region, then scan all of it with ties at the maximum.
    task automatic test_full_table();
        int n;
        for (n = 8; n < FILL_ENTRIES; n++) begin
            if (n == 40 || n == FILL_ENTRIES - 1) begin
                send_item(CMD_LOAD, INDEX_W'(n), make_vec(-32768, -32768, -32768));
            end else begin
                send_item(CMD_LOAD, INDEX_W'(n), random_vec());
            end
        end
        set_cell_count(COUNT_W'(FILL_ENTRIES));
        send_item(CMD_QUERY, '0, make_vec(-32768, -32768, -32768));
        send_item(CMD_QUERY, '1, random_vec());
        set_cell_count(COUNT_W'(FILL_ENTRIES - 1));
        send_item(CMD_QUERY, '0, random_vec());
    endtask

    // Hold the result side for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        int n;
        set_cell_count(13'd24);
        hold_requests <= hold_requests + 1;
        for (n = 0; n < 10; n++) begin
            if (n % 3 == 2) begin
                send_item(CMD_LOAD, INDEX_W'($urandom_range(23)), random_vec());
            end else begin
                send_item(CMD_QUERY, INDEX_W'($urandom), random_vec());
            end
        end
        wait_until_quiet();
    endtask

    // Batches of random loads and queries, each batch under a fresh scan length.
    task automatic test_random_traffic(input int n_items);
        int                 sent;
        int                 batch;
        int                 n;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] idx;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(15))
                0: count = '0;
                1: count = COUNT_W'(FILL_ENTRIES);
                default: count = COUNT_W'($urandom_range(FILL_ENTRIES, 1));
            endcase
            set_cell_count(count);
            batch = $urandom_range(12, 4);
            for (n = 0; n < batch && sent < n_items; n++) begin
                idx = ($urandom_range(3) == 0) ? INDEX_W'($urandom)
                                               : INDEX_W'($urandom_range(FILL_ENTRIES - 1));
                send_item($urandom_range(1) ? CMD_QUERY : CMD_LOAD, idx, random_vec());
                sent++;
            end
        end
    endtask

    // Result side: check each transfer between edges, ahead of the edge that completes it.
    always @(negedge i_clk) begin
        t_best_match expected;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_matches.size() == 0) begin
                flag_error($sformatf("result index %0d score %0d with no query pending",
                                     o_best_index, o_best_score));
            end else begin
                expected = pending_matches.pop_front();
                matches_checked++;
                if (o_best_index !== expected.entry) begin
                    flag_error($sformatf("best_index expected %0d got %0d",
                                         expected.entry, o_best_index));
                end
                if (o_best_score !== expected.score) begin
                    flag_error($sformatf("best_score expected %0d got %0d",
                                         expected.score, o_best_score));
                end
            end
        end
    end

    // Result side: random stall and a long hold on request, counted in cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_matches.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        recv_idle_pct = 56;
        test_empty_scan();
        test_directed_table();
        test_full_table();
        test_random_traffic(17);

        send_idle_pct = 56;
        recv_idle_pct = 14;
        test_output_backpressure();
        test_random_traffic(17);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(17);

        wait_until_quiet();
        $display("Sent %0d loads and %0d queries over %0d scan-length settings (empty to %0d).",
                 loads_sent, queries_sent, count_writes, FILL_ENTRIES);
        $display("Checked %0d results, %0d mismatches.", matches_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
